/* src/rci_pkg.sv */
// shared constants for the ray / vertical cylinder intersection block
// register indexes, fixed datapath widths and step counts
// no dependencies
package rci_pkg;

    localparam int FRAC_BITS = 16;

    // configuration register indexes
    localparam int         CFG_IDX_W  = 2;
    localparam logic [1:0] REG_AXIS_X = 2'd0;
    localparam logic [1:0] REG_AXIS_Z = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam logic [30:0] RADIUS_RESET = 31'd65536;

    // multiplier operand width default and its fixed latency
    localparam int MUL_W   = 32;
    localparam int MUL_LAT = 3;

    // datapath widths
    localparam int MAG_W  = 32;   // |d|, |p| in the x/z plane
    localparam int SQ_W   = 64;   // 32x32 products
    localparam int A_W    = 65;   // a = dx^2 + dz^2
    localparam int H_W    = 66;   // h, c signed
    localparam int HH_W   = 130;  // h^2, a*|c|
    localparam int RAD_W  = 132;  // discriminant, even width for the root
    localparam int ROOT_W = 66;
    localparam int REM_W  = 68;
    localparam int N_W    = 68;   // root choice numerator, signed
    localparam int NM_W   = 67;
    localparam int P_W    = 99;   // |d_k| * |n|
    localparam int NUM_W  = 101;  // 2|p| + a
    localparam int DEN_W  = 66;   // 2a
    localparam int DREM_W = 66;

    localparam int SQRT_STEPS = 66;
    localparam int DIV_STEPS  = 35;

endpackage

/* src/rci_mul.sv */
// pipelined unsigned multiplier, operands split into narrow limbs
// three register stages: partial products, row sums, final sum
// depends on rci_pkg
module rci_mul #(
    parameter int AW = rci_pkg::MUL_W,
    parameter int BW = rci_pkg::MUL_W
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);

    localparam int MW    = (AW > BW) ? AW : BW;
    localparam int NL    = (MW + 23) / 24;
    localparam int LW    = (MW + NL - 1) / NL;
    localparam int PADW  = NL * LW;
    localparam int ROWW  = (NL + 1) * LW;
    localparam int FULLW = 2 * PADW;

    logic [PADW-1:0] a_pad;
    logic [PADW-1:0] b_pad;

    logic [2*LW-1:0]  pp_reg  [NL][NL];
    logic [ROWW-1:0]  row_reg [NL];
    logic [ROWW-1:0]  row_next[NL];
    logic [FULLW-1:0] sum_next;
    logic [AW+BW-1:0] p_reg;

    assign a_pad = PADW'(a);
    assign b_pad = PADW'(b);

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < NL; j++) begin
                row_next[i] = row_next[i] + (ROWW'(pp_reg[i][j]) << (j * LW));
            end
        end
        sum_next = '0;
        for (int i = 0; i < NL; i++) begin
            sum_next = sum_next + (FULLW'(row_reg[i]) << (i * LW));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NL; i++) begin
                for (int j = 0; j < NL; j++) begin
                    pp_reg[i][j] <= a_pad[i*LW +: LW] * b_pad[j*LW +: LW];
                end
                row_reg[i] <= row_next[i];
            end
            p_reg <= sum_next[AW+BW-1:0];
        end
    end

    assign p = p_reg;

endmodule

/* src/ray_cylinder_intersection_top.sv */
// ray / vertical cylinder intersection, fully pipelined, one ray per cycle unless the output stalls
// throughput one ray per cycle whenever the output is not stalled
// depth is set by the 66-step square root and the 35-step rounding dividers
// a stalled output freezes the whole pipeline; nothing is dropped or repeated
// aresetn (synchronous, active low) clears valid bits and loads register defaults
// depends on rci_pkg and rci_mul
module ray_cylinder_intersection_top #(
    parameter int FRAC_BITS = rci_pkg::FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes
    input  logic                          cfg_we,
    input  logic [rci_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    // ray input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [31:0]            s_origin_x,
    input  logic signed [31:0]            s_origin_y,
    input  logic signed [31:0]            s_origin_z,
    input  logic signed [31:0]            s_through_x,
    input  logic signed [31:0]            s_through_y,
    input  logic signed [31:0]            s_through_z,
    // hit output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic signed [31:0]            m_hit_x,
    output logic signed [31:0]            m_hit_y,
    output logic signed [31:0]            m_hit_z
);

    localparam int LAT    = rci_pkg::MUL_LAT;
    localparam int SQN    = rci_pkg::SQRT_STEPS;
    localparam int DVN    = rci_pkg::DIV_STEPS;
    localparam int A_W    = rci_pkg::A_W;
    localparam int H_W    = rci_pkg::H_W;
    localparam int SQ_W   = rci_pkg::SQ_W;
    localparam int HH_W   = rci_pkg::HH_W;
    localparam int RAD_W  = rci_pkg::RAD_W;
    localparam int ROOT_W = rci_pkg::ROOT_W;
    localparam int REM_W  = rci_pkg::REM_W;
    localparam int N_W    = rci_pkg::N_W;
    localparam int NM_W   = rci_pkg::NM_W;
    localparam int P_W    = rci_pkg::P_W;
    localparam int NUM_W  = rci_pkg::NUM_W;
    localparam int DEN_W  = rci_pkg::DEN_W;
    localparam int DREM_W = rci_pkg::DREM_W;
    localparam int MAG_W  = rci_pkg::MAG_W;

    // parallel-ray threshold, round(2^FRAC_BITS / 1000) but never below one
    localparam int          EPS_RAW = ((1 << FRAC_BITS) + 500) / 1000;
    localparam int          EPS     = (EPS_RAW < 1) ? 1 : EPS_RAW;
    localparam logic [31:0] EPS_V   = 32'(EPS);

    // quotient clamp, 2^34
    localparam logic [DVN-1:0] Q_LIMIT = {1'b1, {(DVN-1){1'b0}}};

    // per-ray data that travels alongside the arithmetic
    typedef struct packed {
        logic                  miss;
        logic signed [31:0]    ox;
        logic signed [31:0]    oy;
        logic signed [31:0]    oz;
        logic signed [32:0]    dx;
        logic signed [32:0]    dy;
        logic signed [32:0]    dz;
        logic                  shx;   // sign of px*dx
        logic                  shz;   // sign of pz*dz
        logic [A_W-1:0]        a;
        logic signed [H_W-1:0] h;
    } ray_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [DREM_W-1:0] rem;
        logic [DVN-1:0]    lo;
        logic [DVN-1:0]    q;
    } dv_t;

    function automatic logic [31:0] abs33(input logic signed [32:0] x);
        logic signed [32:0] t;
        t = x[32] ? -x : x;
        return t[31:0];
    endfunction

    // one bit of the restoring square root
    function automatic sq_t sqrt_step(input sq_t cur);
        logic [REM_W+1:0] t;
        logic [REM_W+1:0] trial;
        sq_t              nxt;
        t       = {cur.rem, cur.rad[RAD_W-1 -: 2]};
        trial   = {2'b00, cur.root, 2'b01};
        nxt.rad = {cur.rad[RAD_W-3:0], 2'b00};
        if (t >= trial) begin
            nxt.rem  = REM_W'(t - trial);
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
            nxt.rem  = t[REM_W-1:0];
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

    // one quotient bit of the restoring divider
    function automatic dv_t div_step(input dv_t cur, input logic [DEN_W-1:0] den);
        logic [DREM_W:0] t;
        dv_t             nxt;
        t      = {cur.rem, cur.lo[DVN-1]};
        nxt.lo = {cur.lo[DVN-2:0], 1'b0};
        if (t >= {1'b0, den}) begin
            nxt.rem = DREM_W'(t - {1'b0, den});
            nxt.q   = {cur.q[DVN-2:0], 1'b1};
        end else begin
            nxt.rem = t[DREM_W-1:0];
            nxt.q   = {cur.q[DVN-2:0], 1'b0};
        end
        return nxt;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -37'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // flow control: every stage advances together unless the output
    // holds an untaken result
    // ---------------------------------------------------------------
    logic en;
    logic m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic signed [31:0] axis_x_reg;
    logic signed [31:0] axis_z_reg;
    logic [30:0]        radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_x_reg <= '0;
            axis_z_reg <= '0;
            radius_reg <= rci_pkg::RADIUS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rci_pkg::REG_AXIS_X: axis_x_reg <= cfg_data;
                rci_pkg::REG_AXIS_Z: axis_z_reg <= cfg_data;
                rci_pkg::REG_RADIUS: radius_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // stage 1: direction d = T - O and offset p = O - axis
    // ---------------------------------------------------------------
    logic               v1_reg;
    logic signed [31:0] ox1_reg, oy1_reg, oz1_reg;
    logic signed [32:0] dx1_reg, dy1_reg, dz1_reg, px1_reg, pz1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ox1_reg <= s_origin_x;
            oy1_reg <= s_origin_y;
            oz1_reg <= s_origin_z;
            dx1_reg <= {s_through_x[31], s_through_x} - {s_origin_x[31], s_origin_x};
            dy1_reg <= {s_through_y[31], s_through_y} - {s_origin_y[31], s_origin_y};
            dz1_reg <= {s_through_z[31], s_through_z} - {s_origin_z[31], s_origin_z};
            px1_reg <= {s_origin_x[31], s_origin_x} - {axis_x_reg[31], axis_x_reg};
            pz1_reg <= {s_origin_z[31], s_origin_z} - {axis_z_reg[31], axis_z_reg};
        end
    end

    // ---------------------------------------------------------------
    // stage 2: magnitudes, product signs, nearly-parallel test
    // ---------------------------------------------------------------
    logic             v2_reg;
    ray_t             r2_reg;
    logic [MAG_W-1:0] mdx2_reg, mdz2_reg, mpx2_reg, mpz2_reg;
    logic [MAG_W-1:0] mdx1, mdz1;

    assign mdx1 = abs33(dx1_reg);
    assign mdz1 = abs33(dz1_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            r2_reg.miss <= (mdx1 < EPS_V) && (mdz1 < EPS_V);
            r2_reg.ox   <= ox1_reg;
            r2_reg.oy   <= oy1_reg;
            r2_reg.oz   <= oz1_reg;
            r2_reg.dx   <= dx1_reg;
            r2_reg.dy   <= dy1_reg;
            r2_reg.dz   <= dz1_reg;
            r2_reg.shx  <= px1_reg[32] ^ dx1_reg[32];
            r2_reg.shz  <= pz1_reg[32] ^ dz1_reg[32];
            r2_reg.a    <= '0;
            r2_reg.h    <= '0;
            mdx2_reg    <= mdx1;
            mdz2_reg    <= mdz1;
            mpx2_reg    <= abs33(px1_reg);
            mpz2_reg    <= abs33(pz1_reg);
        end
    end

    // ---------------------------------------------------------------
    // first multiplier bank: squares and cross terms, 32x32
    // ---------------------------------------------------------------
    logic [SQ_W-1:0] dxdx, dzdz, pxdx, pzdz, pxpx, pzpz, rr;

    rci_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_dxdx (
        .aclk(aclk), .en(en), .a(mdx2_reg), .b(mdx2_reg), .p(dxdx));
    rci_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_dzdz (
        .aclk(aclk), .en(en), .a(mdz2_reg), .b(mdz2_reg), .p(dzdz));
    rci_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_pxdx (
        .aclk(aclk), .en(en), .a(mpx2_reg), .b(mdx2_reg), .p(pxdx));
    rci_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_pzdz (
        .aclk(aclk), .en(en), .a(mpz2_reg), .b(mdz2_reg), .p(pzdz));
    rci_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_pxpx (
        .aclk(aclk), .en(en), .a(mpx2_reg), .b(mpx2_reg), .p(pxpx));
    rci_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_pzpz (
        .aclk(aclk), .en(en), .a(mpz2_reg), .b(mpz2_reg), .p(pzpz));
    rci_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_rr (
        .aclk(aclk), .en(en), .a({1'b0, radius_reg}), .b({1'b0, radius_reg}), .p(rr));

    logic [LAT-1:0] va_reg;
    ray_t           ra_reg [LAT];

    always_ff @(posedge aclk) begin
        if (en) begin
            ra_reg[0] <= r2_reg;
            for (int i = 1; i < LAT; i++) begin
                ra_reg[i] <= ra_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 6: quadratic coefficients a, h, c
    // ---------------------------------------------------------------
    logic                  v6_reg;
    ray_t                  r6_reg;
    ray_t                  r6_next;
    logic signed [H_W-1:0] c6_reg;
    logic signed [H_W-1:0] tx6, tz6;

    assign tx6 = ra_reg[LAT-1].shx ? -$signed({2'b00, pxdx}) : $signed({2'b00, pxdx});
    assign tz6 = ra_reg[LAT-1].shz ? -$signed({2'b00, pzdz}) : $signed({2'b00, pzdz});

    always_comb begin
        r6_next   = ra_reg[LAT-1];
        r6_next.a = A_W'(dxdx) + A_W'(dzdz);
        r6_next.h = tx6 + tz6;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r6_reg <= r6_next;
            c6_reg <= $signed({2'b00, pxpx}) + $signed({2'b00, pzpz})
                      - $signed({2'b00, rr});
        end
    end

    // ---------------------------------------------------------------
    // stage 7: magnitudes of h and c
    // ---------------------------------------------------------------
    logic                  v7_reg;
    ray_t                  r7_reg;
    logic [A_W-1:0]        mh7_reg, mc7_reg;
    logic                  cneg7_reg;
    logic signed [H_W-1:0] nh6, nc6;

    assign nh6 = -r6_reg.h;
    assign nc6 = -c6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            r7_reg    <= r6_reg;
            mh7_reg   <= r6_reg.h[H_W-1] ? nh6[A_W-1:0] : r6_reg.h[A_W-1:0];
            mc7_reg   <= c6_reg[H_W-1] ? nc6[A_W-1:0] : c6_reg[A_W-1:0];
            cneg7_reg <= c6_reg[H_W-1];
        end
    end

    // ---------------------------------------------------------------
    // second multiplier bank: h^2 and a*|c|
    // ---------------------------------------------------------------
    logic [HH_W-1:0] hh, ac;

    rci_mul #(.AW(A_W), .BW(A_W)) u_mul_hh (
        .aclk(aclk), .en(en), .a(mh7_reg), .b(mh7_reg), .p(hh));
    rci_mul #(.AW(A_W), .BW(A_W)) u_mul_ac (
        .aclk(aclk), .en(en), .a(r7_reg.a), .b(mc7_reg), .p(ac));

    logic [LAT-1:0] vb_reg;
    logic [LAT-1:0] cnegb_reg;
    ray_t           rb_reg [LAT];

    always_ff @(posedge aclk) begin
        if (en) begin
            rb_reg[0] <= r7_reg;
            for (int i = 1; i < LAT; i++) begin
                rb_reg[i] <= rb_reg[i-1];
            end
            cnegb_reg <= {cnegb_reg[LAT-2:0], cneg7_reg};
        end
    end

    // ---------------------------------------------------------------
    // stage 11: discriminant h^2 - a*c, negative means a miss
    // ---------------------------------------------------------------
    logic             v11_reg;
    ray_t             r11_reg;
    ray_t             r11_next;
    logic [RAD_W-1:0] rad11_reg;
    logic [HH_W:0]    dsum, ddiff;

    assign dsum  = (HH_W+1)'(hh) + (HH_W+1)'(ac);
    assign ddiff = {1'b0, hh} - {1'b0, ac};

    always_comb begin
        r11_next      = rb_reg[LAT-1];
        r11_next.miss = rb_reg[LAT-1].miss || (!cnegb_reg[LAT-1] && ddiff[HH_W]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r11_reg   <= r11_next;
            rad11_reg <= RAD_W'(cnegb_reg[LAT-1] ? dsum : ddiff);
        end
    end

    // ---------------------------------------------------------------
    // square root, one result bit per stage
    // ---------------------------------------------------------------
    logic [SQN-1:0] vs_reg;
    ray_t           rs_reg [SQN];
    sq_t            sq_reg [SQN];
    sq_t            sq_init;

    assign sq_init = '{rad: rad11_reg, rem: '0, root: '0};

    always_ff @(posedge aclk) begin
        if (en) begin
            rs_reg[0] <= r11_reg;
            sq_reg[0] <= sqrt_step(sq_init);
            for (int i = 1; i < SQN; i++) begin
                rs_reg[i] <= rs_reg[i-1];
                sq_reg[i] <= sqrt_step(sq_reg[i-1]);
            end
        end
    end

    // ---------------------------------------------------------------
    // root choice: s - h when h > 0, else -(h + s)
    // ---------------------------------------------------------------
    logic                  vn1_reg;
    ray_t                  rn1_reg;
    logic signed [N_W-1:0] n1_reg;
    logic signed [N_W-1:0] hx, sx;
    logic                  hpos;

    assign hx   = {{(N_W-H_W){rs_reg[SQN-1].h[H_W-1]}}, rs_reg[SQN-1].h};
    assign sx   = {{(N_W-ROOT_W){1'b0}}, sq_reg[SQN-1].root};
    assign hpos = !rs_reg[SQN-1].h[H_W-1] && (rs_reg[SQN-1].h != '0);

    always_ff @(posedge aclk) begin
        if (en) begin
            rn1_reg <= rs_reg[SQN-1];
            n1_reg  <= hpos ? (sx - hx) : (-hx - sx);
        end
    end

    // ---------------------------------------------------------------
    // magnitudes for the per-axis products, product signs
    // ---------------------------------------------------------------
    logic                  vn2_reg;
    ray_t                  rn2_reg;
    logic [NM_W-1:0]       nm2_reg;
    logic [MAG_W-1:0]      dm2_reg [3];
    logic [2:0]            ps2_reg;
    logic signed [N_W-1:0] nneg1;
    logic signed [32:0]    dvec1 [3];

    assign nneg1    = -n1_reg;
    assign dvec1[0] = rn1_reg.dx;
    assign dvec1[1] = rn1_reg.dy;
    assign dvec1[2] = rn1_reg.dz;

    always_ff @(posedge aclk) begin
        if (en) begin
            rn2_reg <= rn1_reg;
            nm2_reg <= n1_reg[N_W-1] ? nneg1[NM_W-1:0] : n1_reg[NM_W-1:0];
            for (int k = 0; k < 3; k++) begin
                dm2_reg[k] <= abs33(dvec1[k]);
                ps2_reg[k] <= dvec1[k][32] ^ n1_reg[N_W-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // third multiplier bank: |d_k| * |n| for each axis
    // ---------------------------------------------------------------
    logic [P_W-1:0] pk [3];

    for (genvar k = 0; k < 3; k++) begin : g_axis_mul
        rci_mul #(.AW(NM_W), .BW(MAG_W)) u_mul_dn (
            .aclk(aclk), .en(en), .a(nm2_reg), .b(dm2_reg[k]), .p(pk[k]));
    end

    logic [LAT-1:0] vc_reg;
    ray_t           rc_reg  [LAT];
    logic [2:0]     psc_reg [LAT];

    always_ff @(posedge aclk) begin
        if (en) begin
            rc_reg[0]  <= rn2_reg;
            psc_reg[0] <= ps2_reg;
            for (int i = 1; i < LAT; i++) begin
                rc_reg[i]  <= rc_reg[i-1];
                psc_reg[i] <= psc_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // divider setup: round(p/a) = floor((2p + a) / 2a), overflow test
    // ---------------------------------------------------------------
    logic             vd0_reg;
    ray_t             rd0_reg;
    logic [NUM_W-1:0] num_d0_reg [3];
    logic [DEN_W-1:0] den_d0_reg;
    logic [2:0]       sat_d0_reg;
    logic [2:0]       ps_d0_reg;
    logic [NUM_W-1:0] num_c [3];
    logic [DEN_W-1:0] den_c;

    assign den_c = {rc_reg[LAT-1].a, 1'b0};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            num_c[k] = (NUM_W'(pk[k]) << 1) + NUM_W'(rc_reg[LAT-1].a);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rd0_reg    <= rc_reg[LAT-1];
            den_d0_reg <= den_c;
            ps_d0_reg  <= psc_reg[LAT-1];
            for (int k = 0; k < 3; k++) begin
                num_d0_reg[k] <= num_c[k];
                // quotient of 2^35 or more is clamped anyway
                sat_d0_reg[k] <= num_c[k][NUM_W-1:DVN] >= den_c;
            end
        end
    end

    // ---------------------------------------------------------------
    // three restoring dividers, one quotient bit per stage
    // ---------------------------------------------------------------
    logic [DVN-1:0]   vq_reg;
    ray_t             rq_reg   [DVN];
    dv_t              dv_reg   [DVN][3];
    logic [DEN_W-1:0] den_q_reg[DVN];
    logic [2:0]       sat_q_reg[DVN];
    logic [2:0]       ps_q_reg [DVN];
    dv_t              dv_init  [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dv_init[k] = '{rem: num_d0_reg[k][NUM_W-1:DVN],
                           lo:  num_d0_reg[k][DVN-1:0],
                           q:   '0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rq_reg[0]    <= rd0_reg;
            den_q_reg[0] <= den_d0_reg;
            sat_q_reg[0] <= sat_d0_reg;
            ps_q_reg[0]  <= ps_d0_reg;
            for (int k = 0; k < 3; k++) begin
                dv_reg[0][k] <= div_step(dv_init[k], den_d0_reg);
            end
            for (int i = 1; i < DVN; i++) begin
                rq_reg[i]    <= rq_reg[i-1];
                den_q_reg[i] <= den_q_reg[i-1];
                sat_q_reg[i] <= sat_q_reg[i-1];
                ps_q_reg[i]  <= ps_q_reg[i-1];
                for (int k = 0; k < 3; k++) begin
                    dv_reg[i][k] <= div_step(dv_reg[i-1][k], den_q_reg[i-1]);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // output stage: clamp quotient, add to origin, saturate, zero on miss
    // ---------------------------------------------------------------
    logic                  m_hit_reg;
    logic signed [31:0]    m_hit_x_reg, m_hit_y_reg, m_hit_z_reg;
    logic signed [31:0]    ovec [3];
    logic signed [31:0]    coord_next [3];
    logic [DVN-1:0]        qc [3];
    logic signed [36:0]    sum_o [3];
    logic                  miss_q;

    assign miss_q  = rq_reg[DVN-1].miss;
    assign ovec[0] = rq_reg[DVN-1].ox;
    assign ovec[1] = rq_reg[DVN-1].oy;
    assign ovec[2] = rq_reg[DVN-1].oz;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (sat_q_reg[DVN-1][k] || (dv_reg[DVN-1][k].q > Q_LIMIT)) begin
                qc[k] = Q_LIMIT;
            end else begin
                qc[k] = dv_reg[DVN-1][k].q;
            end
            if (ps_q_reg[DVN-1][k]) begin
                sum_o[k] = 37'(ovec[k]) - $signed({2'b00, qc[k]});
            end else begin
                sum_o[k] = 37'(ovec[k]) + $signed({2'b00, qc[k]});
            end
            coord_next[k] = miss_q ? 32'sd0 : sat32(sum_o[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_hit_reg   <= !miss_q;
            m_hit_x_reg <= coord_next[0];
            m_hit_y_reg <= coord_next[1];
            m_hit_z_reg <= coord_next[2];
        end
    end

    // ---------------------------------------------------------------
    // valid bits, cleared by reset, moved by the common enable
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            va_reg      <= '0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            vb_reg      <= '0;
            v11_reg     <= 1'b0;
            vs_reg      <= '0;
            vn1_reg     <= 1'b0;
            vn2_reg     <= 1'b0;
            vc_reg      <= '0;
            vd0_reg     <= 1'b0;
            vq_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            va_reg      <= {va_reg[LAT-2:0], v2_reg};
            v6_reg      <= va_reg[LAT-1];
            v7_reg      <= v6_reg;
            vb_reg      <= {vb_reg[LAT-2:0], v7_reg};
            v11_reg     <= vb_reg[LAT-1];
            vs_reg      <= {vs_reg[SQN-2:0], v11_reg};
            vn1_reg     <= vs_reg[SQN-1];
            vn2_reg     <= vn1_reg;
            vc_reg      <= {vc_reg[LAT-2:0], vn2_reg};
            vd0_reg     <= vc_reg[LAT-1];
            vq_reg      <= {vq_reg[DVN-2:0], vd0_reg};
            m_valid_reg <= vq_reg[DVN-1];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_hit   = m_hit_reg;
    assign m_hit_x = m_hit_x_reg;
    assign m_hit_y = m_hit_y_reg;
    assign m_hit_z = m_hit_z_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // a miss always carries zero coordinates
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_hit_reg |-> m_hit_x_reg == 32'sd0 && m_hit_y_reg == 32'sd0
                                      && m_hit_z_reg == 32'sd0)
        else $error("miss result with nonzero coordinates");

    // a held output freezes the long root and divider sections
    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vs_reg) && $stable(vq_reg))
        else $error("pipeline moved while the output was stalled");

    // no input transfer while a finished result waits untaken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !(s_valid && s_ready))
        else $error("input transfer during output stall");

    // nothing valid leaves the pipeline right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("result valid after reset");

endmodule

/* tb/sv/ray_cylinder_intersection_top_tb.sv */
// self-checking testbench for ray_cylinder_intersection_top
// holds its own exact wide-integer predictor of the hit point; depends on rci_pkg
// and the rtl of the block
module ray_cylinder_intersection_top_tb;

    // index that decodes to no register, writes must be dropped
    localparam logic [1:0] REG_NONE = 2'd3;
    localparam longint NEAR_AXIS = ((longint'(1) << rci_pkg::FRAC_BITS) + 500) / 1000;
    localparam int DRAIN_CYCLES = 140;
    localparam int HOLD_LEN     = 400;

    typedef logic signed [199:0] swide_t;
    typedef logic [199:0] uwide_t;

    typedef struct packed {
        logic signed [31:0] ox, oy, oz, tx, ty, tz;
    } ray_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] x, y, z;
    } hit_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_origin_x, s_origin_y, s_origin_z;
    logic signed [31:0] s_through_x, s_through_y, s_through_z;
    logic               m_valid;
    logic               m_ready;
    logic               m_hit;
    logic signed [31:0] m_hit_x, m_hit_y, m_hit_z;

    // shadow copy of the cylinder registers
    logic signed [31:0] cyl_axis_x;
    logic signed [31:0] cyl_axis_z;
    logic [30:0]        cyl_radius;

    hit_t pending_hits[$];
    int   error_count;
    int   src_idle_pct;
    int   snk_idle_pct;
    // long hold-off: requested by the test, counted by the receiver
    logic hold_req;
    logic hold_taken  = 1'b0;
    int   hold_cycles = 0;

    ray_cylinder_intersection_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_origin_x(s_origin_x), .s_origin_y(s_origin_y), .s_origin_z(s_origin_z),
        .s_through_x(s_through_x), .s_through_y(s_through_y),
        .s_through_z(s_through_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit),
        .m_hit_x(m_hit_x), .m_hit_y(m_hit_y), .m_hit_z(m_hit_z)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // generous fixed limit, far beyond the slowest correct run
    initial begin
        #6000000;
        $display("Test completed with failures");
        $finish;
    end

    // exact integer square root, floor
    function automatic uwide_t int_sqrt(uwide_t v);
        uwide_t root;
        uwide_t trial;
        root = '0;
        for (int k = 71; k >= 0; k--) begin
            trial = root | (uwide_t'(1) << k);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    // o + round(dk * n / a), ties away from zero, quotient clamped to 2^34, saturated to 32 bits
    function automatic logic signed [31:0] hit_coord(longint o, longint dk,
                                                      swide_t n, uwide_t a);
        swide_t prod;
        uwide_t mag;
        uwide_t quo;
        longint v;
        prod = swide_t'(dk) * n;
        mag  = (prod < 0) ? uwide_t'(-prod) : uwide_t'(prod);
        quo  = (2 * mag + a) / (2 * a);
        if (quo > (uwide_t'(1) << 34)) quo = uwide_t'(1) << 34;
        v = (prod < 0) ? o - longint'(quo[63:0]) : o + longint'(quo[63:0]);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic hit_t predict_hit(ray_t r);
        hit_t   res;
        longint dx, dy, dz, px, pz;
        swide_t a, h, c, disc, s, n;
        res = '0;
        dx = longint'(r.tx) - longint'(r.ox);
        dy = longint'(r.ty) - longint'(r.oy);
        dz = longint'(r.tz) - longint'(r.oz);
        // nearly parallel to the axis, or a degenerate ray
        if ((dx < NEAR_AXIS && -dx < NEAR_AXIS) && (dz < NEAR_AXIS && -dz < NEAR_AXIS))
            return res;
        px = longint'(r.ox) - longint'(cyl_axis_x);
        pz = longint'(r.oz) - longint'(cyl_axis_z);
        a = swide_t'(dx) * swide_t'(dx) + swide_t'(dz) * swide_t'(dz);
        h = swide_t'(px) * swide_t'(dx) + swide_t'(pz) * swide_t'(dz);
        c = swide_t'(px) * swide_t'(px) + swide_t'(pz) * swide_t'(pz)
          - swide_t'({1'b0, cyl_radius}) * swide_t'({1'b0, cyl_radius});
        disc = h * h - a * c;
        if (disc < 0) return res;
        s = swide_t'(int_sqrt(uwide_t'(disc)));
        // smaller-magnitude root
        n = (h > 0) ? s - h : -(h + s);
        res.hit = 1'b1;
        res.x = hit_coord(longint'(r.ox), dx, n, uwide_t'(a));
        res.y = hit_coord(longint'(r.oy), dy, n, uwide_t'(a));
        res.z = hit_coord(longint'(r.oz), dz, n, uwide_t'(a));
        return res;
    endfunction

    // result checker
    always @(posedge aclk) begin
        hit_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_hits.size() == 0) begin
                $display("%0t: unexpected result hit=%0b x=%0d y=%0d z=%0d",
                         $time, m_hit, m_hit_x, m_hit_y, m_hit_z);
                error_count++;
            end else begin
                want = pending_hits.pop_front();
                if (m_hit !== want.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, m_hit);
                    error_count++;
                end
                if (m_hit_x !== want.x) begin
                    $display("%0t: hit_x expected %0d actual %0d", $time, want.x, m_hit_x);
                    error_count++;
                end
                if (m_hit_y !== want.y) begin
                    $display("%0t: hit_y expected %0d actual %0d", $time, want.y, m_hit_y);
                    error_count++;
                end
                if (m_hit_z !== want.z) begin
                    $display("%0t: hit_z expected %0d actual %0d", $time, want.z, m_hit_z);
                    error_count++;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken  <= 1'b1;
            hold_cycles <= HOLD_LEN - 1;
            m_ready     <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // one ray transfer; valid stays high into the next ray when no gap is taken
    task automatic send_ray(ray_t r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_origin_x  <= r.ox;
        s_origin_y  <= r.oy;
        s_origin_z  <= r.oz;
        s_through_x <= r.tx;
        s_through_y <= r.ty;
        s_through_z <= r.tz;
        do @(posedge aclk); while (!s_ready);
        pending_hits.push_back(predict_hit(r));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            rci_pkg::REG_AXIS_X: cyl_axis_x = data;
            rci_pkg::REG_AXIS_Z: cyl_axis_z = data;
            rci_pkg::REG_RADIUS: cyl_radius = data[30:0];
            default: ;
        endcase
    endtask

    // any magnitude from a few lsbs up to the full range
    function automatic logic signed [31:0] rand_coord();
        return $signed($urandom) >>> $urandom_range(31);
    endfunction

    // mostly rays aimed near the axis so that hits are common, rest is noise or nearly vertical rays
    function automatic ray_t rand_ray();
        ray_t r;
        int   spread;
        r = '0;
        case ($urandom_range(9))
            0, 1: begin
                r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
                r.tx = $urandom; r.ty = $urandom; r.tz = $urandom;
            end
            2: begin
                // nearly vertical ray
                r.ox = rand_coord(); r.oy = rand_coord(); r.oz = rand_coord();
                r.tx = r.ox + $signed($urandom_range(130)) - 65;
                r.ty = rand_coord();
                r.tz = r.oz + $signed($urandom_range(130)) - 65;
            end
            default: begin
                spread = $urandom_range(8, 30);
                r.ox = cyl_axis_x + rand_coord();
                r.oz = cyl_axis_z + rand_coord();
                r.oy = rand_coord();
                r.tx = cyl_axis_x + ($signed($urandom) >>> spread);
                r.tz = cyl_axis_z + ($signed($urandom) >>> spread);
                r.ty = rand_coord();
            end
        endcase
        return r;
    endfunction

    task automatic send_random(int count);
        repeat (count) send_ray(rand_ray());
    endtask

    // extremes of every field and the special cases, at reset registers
    task automatic test_directed();
        ray_t r;
        // degenerate ray, through equals origin
        r = '{ox: 32'sd1000, oy: 32'sd5, oz: -32'sd7, tx: 32'sd1000, ty: 32'sd5,
              tz: -32'sd7};
        send_ray(r);
        // offsets just below and at the parallel threshold
        r = '{ox: 0, oy: 0, oz: 0, tx: 32'(NEAR_AXIS - 1), ty: 32'sd65536,
              tz: 32'(NEAR_AXIS - 1)};
        send_ray(r);
        r.tx = 32'(NEAR_AXIS);
        send_ray(r);
        // origin outside, aimed at the axis along x: two roots, smaller one
        r = '{ox: -32'sd196608, oy: 32'sd65536, oz: 0, tx: 0, ty: 32'sd131072, tz: 0};
        send_ray(r);
        // origin inside, h zero: roots of equal magnitude
        r = '{ox: 0, oy: 0, oz: 0, tx: 32'sd65536, ty: 0, tz: 0};
        send_ray(r);
        // origin outside moving away, h positive
        r = '{ox: 32'sd196608, oy: 0, oz: 32'sd100, tx: 32'sd262144, ty: 32'sd7,
              tz: 32'sd100};
        send_ray(r);
        // tangent line, discriminant zero
        r = '{ox: -32'sd131072, oy: 0, oz: 32'sd65536, tx: 32'sd131072, ty: 0,
              tz: 32'sd65536};
        send_ray(r);
        // passes outside, negative discriminant
        r = '{ox: -32'sd131072, oy: 0, oz: 32'sd131072, tx: 32'sd131072, ty: 0,
              tz: 32'sd131072};
        send_ray(r);
        // extremes, steep y so the hit point saturates
        r = '{ox: 32'h8000_0000, oy: 32'h8000_0000, oz: 32'h8000_0000,
              tx: 32'h7fff_ffff, ty: 32'h7fff_ffff, tz: 32'h7fff_ffff};
        send_ray(r);
        r = '{ox: 32'h7fff_ffff, oy: 32'h7fff_ffff, oz: 0,
              tx: 32'h8000_0000, ty: 32'h8000_0000, tz: 0};
        send_ray(r);
        r = '{ox: -32'sd65536, oy: 32'h7fff_0000, oz: 0, tx: -32'sd65470,
              ty: 32'h8000_0000, tz: 0};
        send_ray(r);
        r = '{ox: -32'sd1, oy: -32'sd1, oz: -32'sd1, tx: 32'sd1, ty: 32'sd1, tz: 32'sd1};
        send_ray(r);
        r = '{ox: 0, oy: 0, oz: 32'h8000_0000, tx: 0, ty: 32'h7fff_ffff, tz: 32'h7fff_ffff};
        send_ray(r);
    endtask

    // sweep the registers through several settings including extremes
    task automatic test_register_sweep();
        logic signed [31:0] ax[6] = '{32'h7fff_ffff, 32'h8000_0000, 32'sd131072,
                                       -32'sd50000, 0, 32'sd3};
        logic signed [31:0] az[6] = '{32'h8000_0000, 32'h7fff_ffff, -32'sd65536,
                                       32'sd777, 0, -32'sd3};
        logic [31:0]        rd[6] = '{32'h7fff_ffff, 0, 32'sd1, 32'hffff_ffff,
                                       32'sd300000, 32'sd65536};
        for (int i = 0; i < 6; i++) begin
            write_reg(rci_pkg::REG_AXIS_X, ax[i]);
            write_reg(rci_pkg::REG_AXIS_Z, az[i]);
            write_reg(rci_pkg::REG_RADIUS, rd[i]);
            send_random(25);
        end
        // write to an unused index must leave every register alone
        write_reg(REG_NONE, 32'h1234_5678);
        send_random(15);
    endtask

    // random rays through the three idle patterns with random registers
    task automatic test_random_traffic();
        int src_pct[3] = '{11, 58, 0};
        int snk_pct[3] = '{58, 11, 0};
        for (int p = 0; p < 3; p++) begin
            src_idle_pct = src_pct[p];
            snk_idle_pct = snk_pct[p];
            write_reg(rci_pkg::REG_AXIS_X, rand_coord());
            write_reg(rci_pkg::REG_AXIS_Z, rand_coord());
            write_reg(rci_pkg::REG_RADIUS, $urandom >> $urandom_range(1, 31));
            send_random(210);
        end
    endtask

    // long receiver hold-off while rays keep coming: pipeline fills and stalls
    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 20;
        write_reg(rci_pkg::REG_RADIUS, 32'sd262144);
        @(posedge aclk);
        hold_req = 1'b1;
        send_random(250);
    endtask

    initial begin
        error_count  = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req     = 1'b0;
        cyl_axis_x   = '0;
        cyl_axis_z   = '0;
        cyl_radius   = rci_pkg::RADIUS_RESET;
        aresetn     <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= rci_pkg::REG_AXIS_X;
        cfg_data    <= '0;
        s_valid     <= 1'b0;
        s_origin_x  <= '0;
        s_origin_y  <= '0;
        s_origin_z  <= '0;
        s_through_x <= '0;
        s_through_y <= '0;
        s_through_z <= '0;
        m_ready     <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_register_sweep();
        test_random_traffic();
        test_backpressure();
        wait_drained();

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
